### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/pcchm_pkg.sv
// ----------------------------------------------------------------------------
// pcchm_pkg
// Types and constants shared by the pixel code colour map modules.
// ----------------------------------------------------------------------------
package pcchm_pkg;

  // Default sizes.
  localparam int unsigned DefBuckets      = 257;
  localparam int unsigned DefMaxEntries   = 256;
  localparam int unsigned DefMaxCodeChars = 2;
  localparam int unsigned QueueDepth      = 2;

  // Bucket arithmetic: the sum of two characters fits in nine bits.
  localparam int unsigned SumW        = 9;
  localparam int unsigned RecipShift  = 18;

  // Configuration port.
  localparam int unsigned AddrW        = 3;
  localparam int unsigned DataW        = 32;
  localparam logic        RegCodeLength = 1'b0;   // register index, paddr[2]
  localparam logic [1:0]  CodeLengthRst = 2'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] code_first;
    logic [7:0] code_second;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       dropped;
  } rsp_t;

  // A classified request as the back end sees it.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] code;       // second character in the upper byte
    logic [31:0] colour;     // alpha, blue, green, red from top to bottom
    logic        two_chars;
  } job_t;

endpackage

### hdl/pixel_code_colour_hash_map.sv
// ----------------------------------------------------------------------------
// pixel_code_colour_hash_map
// Chained hash map from one- or two-character pixel codes to RGBA colours.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Handshake                  Moves
//  ----------  ---------  -------------------------  ----------------------------
//  request     in         push high, full low        req_i (command, code, colour)
//  result      out        pop high, empty low        rsp_o (found, colour, dropped)
//  register    in/out     psel, penable, pready      code_length at byte address 0
//
//  A request is registered in the front end and then passes through the queue
//  behind it, which overlaps with the back end. The back end dispatches a
//  job from its idle state; an insert then writes its entry, and a lookup
//  reads the bucket head and then visits the chain one entry at a time.
//  A clear sweeps every bucket to empty through the bucket memory's single
//  write port. After reset the bucket memory is swept to empty, during
//  which full is held high; register writes are taken as ever.
//  A stalled result side fills the result queue and then the request queue,
//  after which full rises.
//
module pixel_code_colour_hash_map #(
  parameter int unsigned BUCKETS        = pcchm_pkg::DefBuckets,
  parameter int unsigned MAX_ENTRIES    = pcchm_pkg::DefMaxEntries,
  parameter int unsigned MAX_CODE_CHARS = pcchm_pkg::DefMaxCodeChars
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            push,
  output logic                            full,
  input  pcchm_pkg::req_t                 req_i,
  // result channel
  output logic                            empty,
  input  logic                            pop,
  output pcchm_pkg::rsp_t                 rsp_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcchm_pkg::AddrW-1:0]     paddr,
  input  logic [pcchm_pkg::DataW-1:0]     pwdata,
  output logic [pcchm_pkg::DataW-1:0]     prdata,
  output logic                            pready
);

  import pcchm_pkg::*;

  localparam int unsigned BktW = $clog2(BUCKETS);
  localparam int unsigned JobW = $bits(job_t) + BktW;
  localparam int unsigned RspW = $bits(rsp_t);

  // Register port: pready is tied high, so every access completes at once.
  logic [1:0] code_length_q;
  logic       cfg_write;
  logic       two_chars;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegCodeLength) ? DataW'(code_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= CodeLengthRst;
    end else if (cfg_write && (paddr[2] == RegCodeLength)) begin
      code_length_q <= pwdata[1:0];
    end
  end

  // A length of 0 acts as 1 and 3 as 2, so the upper bit alone decides
  // whether the second character takes part.
  assign two_chars = code_length_q[1] && (MAX_CODE_CHARS >= 2);

  // Front end: registers the request and computes its bucket.
  logic            front_hold;
  logic            job_full;
  logic            job_push;
  job_t            front_job;
  logic [BktW-1:0] front_bucket;

  pcchm_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (front_hold),
    .push_i      (push),
    .req_i       (req_i),
    .two_chars_i (two_chars),
    .full_o      (full),
    .job_full_i  (job_full),
    .job_push_o  (job_push),
    .job_o       (front_job),
    .bucket_o    (front_bucket)
  );

  // Queue between the front and back ends.
  logic [JobW-1:0] job_word;
  logic            job_empty;
  logic            job_pop;
  job_t            back_job;
  logic [BktW-1:0] back_bucket;

  pcchm_fifo #(
    .WIDTH (JobW),
    .DEPTH (QueueDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({front_bucket, front_job}),
    .pop_i   (job_pop),
    .data_o  (job_word),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  assign {back_bucket, back_job} = job_word;

  // Back end: owns the bucket heads, the entry pool and the entry count.
  logic rsp_full;
  logic rsp_push;
  rsp_t back_rsp;

  pcchm_back #(
    .BUCKETS     (BUCKETS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_i       (back_job),
    .bucket_i    (back_bucket),
    .job_pop_o   (job_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (back_rsp),
    .init_busy_o (front_hold)
  );

  // Result queue: decouples the back end from a stalled consumer.
  logic [RspW-1:0] rsp_word;

  pcchm_fifo #(
    .WIDTH (RspW),
    .DEPTH (QueueDepth)
  ) u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (back_rsp),
    .pop_i   (pop),
    .data_o  (rsp_word),
    .full_o  (rsp_full),
    .empty_o (empty)
  );

  assign rsp_o = rsp_word;

  // Checks on the internal queues and the register port.
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_rsp_overflow, clk_i, rst_ni, rsp_push && rsp_full, "result queue overflow")
  `ASSERT_NEVER(a_job_underflow, clk_i, rst_ni, job_pop && job_empty, "request queue underflow")
  `ASSERT_CLK(a_cfg_readback, clk_i, rst_ni, cfg_write && (paddr[2] == RegCodeLength) |=> code_length_q == $past(pwdata[1:0]), "code_length write lost")

endmodule

### hdl/pcchm_fifo.sv
// ----------------------------------------------------------------------------
// pcchm_fifo
// Small first-in first-out queue built from registers.
// ----------------------------------------------------------------------------
module pcchm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/pcchm_front.sv
// ----------------------------------------------------------------------------
// pcchm_front
// Accepts requests, masks the code and works out the bucket index.
// ----------------------------------------------------------------------------
module pcchm_front #(
  parameter int unsigned BUCKETS = 257
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         hold_i,
  input  logic                         push_i,
  input  pcchm_pkg::req_t              req_i,
  input  logic                         two_chars_i,
  output logic                         full_o,
  input  logic                         job_full_i,
  output logic                         job_push_o,
  output pcchm_pkg::job_t              job_o,
  output logic [$clog2(BUCKETS)-1:0]   bucket_o
);

  import pcchm_pkg::*;

  localparam int unsigned BktW   = $clog2(BUCKETS);
  localparam int unsigned Recip  = (1 << RecipShift) / BUCKETS;
  localparam int unsigned ProdW  = SumW + RecipShift;

  logic              valid_q, valid_d;
  logic              accept;
  job_t              job_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [7:0]        second;
  logic [SumW-1:0]   quot, quot_b, rem;

  assign full_o     = hold_i || (valid_q && job_full_i);
  assign accept     = push_i && !full_o;
  assign job_push_o = valid_q && !job_full_i;
  assign job_o      = job_q;

  // The reciprocal estimate of the quotient is never high and at most one low.
  assign second = two_chars_i ? req_i.code_second : 8'd0;
  assign sum_d  = SumW'(req_i.code_first) + SumW'(second);
  assign prod_d = ProdW'(sum_d) * ProdW'(Recip);

  assign quot   = prod_q[ProdW-1:RecipShift];
  assign quot_b = SumW'(quot * BUCKETS);
  assign rem    = sum_q - quot_b;

  always_comb begin
    if (32'(rem) >= BUCKETS) begin
      bucket_o = BktW'(32'(rem) - BUCKETS);
    end else begin
      bucket_o = BktW'(rem);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (job_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.cmd       <= req_i.cmd;
      job_q.code      <= {second, req_i.code_first};
      job_q.colour    <= {req_i.alpha_in, req_i.blue_in, req_i.green_in, req_i.red_in};
      job_q.two_chars <= two_chars_i;
      sum_q           <= sum_d;
      prod_q          <= prod_d;
    end
  end

endmodule

### hdl/pcchm_back.sv
// ----------------------------------------------------------------------------
// pcchm_back
// Carries out clear, insert and lookup on the bucket and entry memories.
// ----------------------------------------------------------------------------
module pcchm_back #(
  parameter int unsigned BUCKETS     = 257,
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  pcchm_pkg::job_t              job_i,
  input  logic [$clog2(BUCKETS)-1:0]   bucket_i,
  output logic                         job_pop_o,
  input  logic                         rsp_full_i,
  output logic                         rsp_push_o,
  output pcchm_pkg::rsp_t              rsp_o,
  output logic                         init_busy_o
);

  import pcchm_pkg::*;

  localparam int unsigned BktW   = $clog2(BUCKETS);
  localparam int unsigned PtrW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EAddrW = $clog2(MAX_ENTRIES);
  localparam int unsigned EntW   = 16 + 32 + PtrW;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_HEAD  = 3'd3;
  localparam logic [2:0] ST_CHAIN = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [BktW-1:0]   sweep_q, sweep_d;
  logic              reply_q, reply_d;
  logic [PtrW-1:0]   count_q, count_d;
  job_t              job_q, job_d;
  logic [BktW-1:0]   bkt_q, bkt_d;

  logic [PtrW-1:0]   head_mem [BUCKETS];
  logic [PtrW-1:0]   head_rdata_q;
  logic              head_we;
  logic [BktW-1:0]   head_waddr;
  logic [PtrW-1:0]   head_wdata;

  logic [EntW-1:0]   entry_mem [MAX_ENTRIES];
  logic [EntW-1:0]   entry_rdata_q;
  logic              entry_we;
  logic [EAddrW-1:0] entry_raddr;
  logic [EntW-1:0]   entry_wdata;

  logic [15:0]       e_code;
  logic [31:0]       e_colour;
  logic [PtrW-1:0]   e_link;
  logic              e_match;

  assign {e_code, e_colour, e_link} = entry_rdata_q;
  assign e_match = (e_code[7:0] == job_q.code[7:0]) &&
                   (!job_q.two_chars || (e_code[15:8] == job_q.code[15:8]));
  assign entry_wdata = {job_q.code, job_q.colour, head_rdata_q};
  assign init_busy_o = (state_q == ST_SWEEP) && !reply_q;

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    reply_d     = reply_q;
    count_d     = count_q;
    job_d       = job_q;
    bkt_d       = bkt_q;
    job_pop_o   = 1'b0;
    rsp_push_o  = 1'b0;
    rsp_o       = '0;
    head_we     = 1'b0;
    head_waddr  = bkt_q;
    head_wdata  = '0;
    entry_we    = 1'b0;
    entry_raddr = '0;
    unique case (state_q)
      ST_SWEEP: begin
        head_we    = 1'b1;
        head_waddr = sweep_q;
        if (sweep_q == BktW'(BUCKETS - 1)) begin
          state_d    = ST_IDLE;
          rsp_push_o = reply_q;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (job_valid_i && !rsp_full_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          bkt_d     = bucket_i;
          unique case (job_i.cmd)
            CMD_CLEAR: begin
              state_d = ST_SWEEP;
              sweep_d = '0;
              reply_d = 1'b1;
              count_d = '0;
            end
            CMD_INSERT: begin
              if (count_q == PtrW'(MAX_ENTRIES)) begin
                rsp_push_o    = 1'b1;
                rsp_o.dropped = 1'b1;
              end else begin
                state_d = ST_INS;
              end
            end
            CMD_LOOKUP: begin
              state_d = ST_HEAD;
            end
            default: begin
              rsp_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_INS: begin
        entry_we   = 1'b1;
        head_we    = 1'b1;
        head_wdata = count_q + 1'b1;
        count_d    = count_q + 1'b1;
        rsp_push_o = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_HEAD: begin
        if (head_rdata_q == '0) begin
          rsp_push_o = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          entry_raddr = EAddrW'(head_rdata_q - 1'b1);
          state_d     = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        // Links always point to older entries, so every chain ends.
        if (e_match) begin
          rsp_push_o      = 1'b1;
          rsp_o.found     = 1'b1;
          rsp_o.red_out   = e_colour[7:0];
          rsp_o.green_out = e_colour[15:8];
          rsp_o.blue_out  = e_colour[23:16];
          rsp_o.alpha_out = e_colour[31:24];
          state_d         = ST_IDLE;
        end else if (e_link == '0) begin
          rsp_push_o = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          entry_raddr = EAddrW'(e_link - 1'b1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      sweep_q <= '0;
      reply_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      reply_q <= reply_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    bkt_q <= bkt_d;
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata_q <= head_mem[bucket_i];
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[count_q[EAddrW-1:0]] <= entry_wdata;
    end
    entry_rdata_q <= entry_mem[entry_raddr];
  end

endmodule
